// ===== src/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg - shared definitions for the Legendre recurrence core
// Widths, fixed-point constants and the divider status bundle.
// ----------------------------------------------------------------------------
package lfr_pkg;

	// data and degree widths
	localparam int DATA_W    = 32;
	localparam int DEG_W     = 6;
	localparam int FRAC_BITS = 30;

	// shared multiplier: 33 x 33 signed
	localparam int MUL_W  = DATA_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	// numerator accumulator and scaled dividend
	localparam int ACC_W = 72;
	localparam int NUM_W = ACC_W - FRAC_BITS;
	localparam int QUO_W = DATA_W;
	localparam int HI_W  = NUM_W - QUO_W;
	localparam int CNT_W = 6;

	// register reset and P_0 value (1.0)
	localparam logic [DEG_W-1:0]         MAX_DEGREE_RST = 6'd50;
	localparam logic signed [DATA_W-1:0] ONE_Q          = 32'sh4000_0000;

	// divider status
	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

endpackage

// ===== src/lfr_if.sv =====
// ----------------------------------------------------------------------------
// lfr_if - request channels of the Legendre recurrence core
// Argument channel (x in) and result channel (degree, P value, last flag).
// ----------------------------------------------------------------------------
interface lfr_arg_if import lfr_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] x_value;

	modport source (output valid, output x_value, input ready);
	modport sink   (input valid, input x_value, output ready);
endinterface

interface lfr_res_if import lfr_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [DEG_W-1:0]         degree;
	logic signed [DATA_W-1:0] p_value;
	logic                     last;

	modport source (output valid, output degree, output p_value, output last, input ready);
	modport sink   (input valid, input degree, input p_value, input last, output ready);
endinterface

// ===== src/lfr_mul.sv =====
// ----------------------------------------------------------------------------
// lfr_mul - shared signed multiplier
// One 33 x 33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module lfr_mul import lfr_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod_q
);

	// product register
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// ===== src/lfr_div.sv =====
// ----------------------------------------------------------------------------
// lfr_div - bit-serial divider for the recurrence
// Divides a 42-bit dividend by a 6-bit divisor, one quotient bit per cycle.
// Flags saturation up front when the quotient cannot fit in 32 bits.
// ----------------------------------------------------------------------------
module lfr_div import lfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEG_W-1:0]  den,
	output div_stat_t         stat,
	output logic [QUO_W-1:0]  quot
);

	logic             busy_q;
	logic             done_q;
	logic             sat_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEG_W-1:0] rem_q;
	logic [QUO_W-1:0] quot_q;

	logic [DEG_W:0]   trial;
	logic [DEG_W:0]   diff;
	logic             ge;
	logic [DEG_W-1:0] rem_next;
	logic             overflow;

	// quotient of 2^32 or more when the upper dividend bits reach the divisor
	assign overflow = num[NUM_W-1:QUO_W] >= HI_W'(den);

	// restoring step
	assign trial    = {rem_q, quot_q[QUO_W-1]};
	assign ge       = trial >= {1'b0, den};
	assign diff     = trial - {1'b0, den};
	assign rem_next = ge ? diff[DEG_W-1:0] : trial[DEG_W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (overflow) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					sat_q  <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					sat_q  <= 1'b0;
					cnt_q  <= CNT_W'(QUO_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[QUO_W +: DEG_W];
			quot_q <= num[QUO_W-1:0];
		end else if (busy_q) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[QUO_W-2:0], ge};
		end
	end

	assign stat.done = done_q;
	assign stat.sat  = sat_q;
	assign quot      = quot_q;

endmodule

// ===== src/legendre_forward_recurrence_core.sv =====
// ----------------------------------------------------------------------------
// legendre_forward_recurrence_core - Legendre polynomials by Bonnet recurrence
// Emits P_0(x) .. P_D(x) in Q2.30 for each argument, D from max_degree.
// P_0 is registered from state S_EMIT0 once the request is taken, P_1 from S_EMIT1.
// Each higher degree runs the multiplier states, rounding and the bit-serial
// divider, which flags saturation up front, before the result is emitted.
// One argument at a time. Reset clears the sequencer; max_degree resets to 50.
// ----------------------------------------------------------------------------
module legendre_forward_recurrence_core import lfr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [DEG_W-1:0] cfg_wr_data,
	lfr_arg_if.sink          arg,
	lfr_res_if.source        poly
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_EMIT0 = 12'b0000_0000_0010,
		S_EMIT1 = 12'b0000_0000_0100,
		S_MXP   = 12'b0000_0000_1000,
		S_MLO   = 12'b0000_0001_0000,
		S_MHI   = 12'b0000_0010_0000,
		S_MPM   = 12'b0000_0100_0000,
		S_MSUB  = 12'b0000_1000_0000,
		S_MAG   = 12'b0001_0000_0000,
		S_RND   = 12'b0010_0000_0000,
		S_DIV   = 12'b0100_0000_0000,
		S_EMIT  = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	logic [DEG_W-1:0]         maxdeg_q;
	logic [DEG_W-1:0]         dmax_q;
	logic [DEG_W-1:0]         deg_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] pl_q;
	logic signed [DATA_W-1:0] pm_q;
	logic signed [DATA_W-1:0] xhi_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     neg_q;

	logic                     out_valid_q;
	logic [DEG_W-1:0]         out_deg_q;
	logic signed [DATA_W-1:0] out_p_q;
	logic                     out_last_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  prod_ext;

	logic [ACC_W-1:0]         half;
	logic [ACC_W-1:0]         rnd_sum;
	logic [DEG_W-1:0]         deg_next;
	logic                     div_start;
	div_stat_t                div_stat;
	logic [QUO_W-1:0]         div_quot;

	logic [DATA_W-1:0]        lim;
	logic [DATA_W-1:0]        qmag;
	logic signed [DATA_W-1:0] res;
	logic                     out_free;
	logic                     take;
	logic                     emit_now;

	// handshakes
	assign take     = arg.valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || poly.ready;
	assign deg_next = deg_q + 1'b1;
	assign emit_now = out_free &&
		((state_q == S_EMIT0) || (state_q == S_EMIT1) || (state_q == S_EMIT));

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MXP: begin
				mul_a = {x_q[DATA_W-1], x_q};
				mul_b = {pl_q[DATA_W-1], pl_q};
			end
			S_MLO: begin
				mul_a = {1'b0, prod_q[DATA_W-1:0]};
				mul_b = MUL_W'({deg_q, 1'b1});
			end
			S_MHI: begin
				mul_a = {xhi_q[DATA_W-1], xhi_q};
				mul_b = MUL_W'({deg_q, 1'b1});
			end
			S_MPM: begin
				mul_a = {pm_q[DATA_W-1], pm_q};
				mul_b = MUL_W'(deg_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	lfr_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

	// rounding: add half of (l+1)*2^FRAC_BITS, drop the fraction scale
	assign half      = ACC_W'({1'b0, deg_q} + 7'd1) << (FRAC_BITS - 1);
	assign rnd_sum   = acc_q + half;
	assign div_start = (state_q == S_RND);

	lfr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rnd_sum[ACC_W-1:FRAC_BITS]),
		.den    (deg_next),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// saturate and restore sign
	always_comb begin
		lim = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		if (div_stat.sat || (div_quot > lim))
			qmag = lim;
		else
			qmag = div_quot;
		res = neg_q ? $signed(~qmag + 1'b1) : $signed(qmag);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxdeg_q <= MAX_DEGREE_RST;
		end else if (cfg_wr_en) begin
			maxdeg_q <= cfg_wr_data;
		end
	end

	// output valid: set on a new result, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now) begin
			out_valid_q <= 1'b1;
		end else if (poly.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take)
						state_q <= S_EMIT0;
				end
				S_EMIT0: begin
					if (out_free)
						state_q <= (dmax_q == '0) ? S_IDLE : S_EMIT1;
				end
				S_EMIT1: begin
					if (out_free)
						state_q <= (dmax_q == DEG_W'(1)) ? S_IDLE : S_MXP;
				end
				S_MXP:  state_q <= S_MLO;
				S_MLO:  state_q <= S_MHI;
				S_MHI:  state_q <= S_MPM;
				S_MPM:  state_q <= S_MSUB;
				S_MSUB: state_q <= S_MAG;
				S_MAG:  state_q <= S_RND;
				S_RND:  state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free)
						state_q <= (deg_next == dmax_q) ? S_IDLE : S_MXP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (take) begin
					x_q    <= arg.x_value;
					dmax_q <= maxdeg_q;
				end
			end
			S_EMIT0: begin
				if (out_free) begin
					out_deg_q  <= '0;
					out_p_q    <= ONE_Q;
					out_last_q <= (dmax_q == '0);
					pl_q       <= ONE_Q;
				end
			end
			S_EMIT1: begin
				if (out_free) begin
					out_deg_q  <= DEG_W'(1);
					out_p_q    <= x_q;
					out_last_q <= (dmax_q == DEG_W'(1));
					pm_q       <= pl_q;
					pl_q       <= x_q;
					deg_q      <= DEG_W'(1);
				end
			end
			S_MLO: begin
				xhi_q <= prod_q[2*DATA_W-1:DATA_W];
			end
			S_MHI: begin
				acc_q <= prod_ext;
			end
			S_MPM: begin
				acc_q <= acc_q + (prod_ext <<< DATA_W);
			end
			S_MSUB: begin
				acc_q <= acc_q - (prod_ext <<< FRAC_BITS);
			end
			S_MAG: begin
				neg_q <= acc_q[ACC_W-1];
				if (acc_q[ACC_W-1])
					acc_q <= -acc_q;
			end
			S_EMIT: begin
				if (out_free) begin
					out_deg_q  <= deg_next;
					out_p_q    <= res;
					out_last_q <= (deg_next == dmax_q);
					pm_q       <= pl_q;
					pl_q       <= res;
					deg_q      <= deg_next;
				end
			end
			default: begin
			end
		endcase
	end

	// port drive
	assign arg.ready    = (state_q == S_IDLE);
	assign poly.valid   = out_valid_q;
	assign poly.degree  = out_deg_q;
	assign poly.p_value = out_p_q;
	assign poly.last    = out_last_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for legendre_forward_recurrence_core
// Feeds arguments under a series of max_degree settings. Each accepted
// argument is expanded into its run of P_0..P_D by a 128-bit Bonnet recurrence
// (round-to-nearest, saturating) or from literal values for typed rows. Every
// result is checked in order against that run. Sender and receiver both throttle.
// ----------------------------------------------------------------------------
module tb;
	import lfr_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 100;

	localparam logic signed [DATA_W-1:0] NEG_ONE  = 32'shC000_0000;
	localparam logic signed [DATA_W-1:0] HALF_Q   = 32'sh2000_0000;
	localparam logic signed [DATA_W-1:0] NEG_HALF = 32'shE000_0000;
	localparam logic signed [DATA_W-1:0] MAX_POS  = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MAX_NEG  = 32'sh8000_0000;

	typedef struct packed {
		logic [DEG_W-1:0]         degree;
		logic signed [DATA_W-1:0] p_value;
		logic                     last;
	} poly_res_t;

	// directed row: degree setting, argument, and literal P values when typed
	typedef struct packed {
		logic [DEG_W-1:0]         deg;
		logic signed [DATA_W-1:0] x;
		bit                       typed;
		logic signed [DATA_W-1:0] p_even;
		logic signed [DATA_W-1:0] p_odd;
	} dir_row_t;

	typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_COIN, RDY_DUTY} stall_mode_t;

	localparam int N_DIR = 21;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// reset setting, exact endpoints: P_l(1) = 1, P_l(-1) = (-1)^l
		'{6'd50, ONE_Q,         1'b1, ONE_Q, ONE_Q},
		'{6'd50, NEG_ONE,       1'b1, ONE_Q, NEG_ONE},
		// zero degree: P_0 only, flagged last
		'{6'd0,  HALF_Q,        1'b1, ONE_Q, ONE_Q},
		'{6'd0,  MAX_NEG,       1'b1, ONE_Q, ONE_Q},
		// degree 1: P_1 is x as given, even out of range
		'{6'd1,  32'sh0,        1'b1, ONE_Q, 32'sh0},
		'{6'd1,  MAX_POS,       1'b1, ONE_Q, MAX_POS},
		'{6'd1,  MAX_NEG,       1'b1, ONE_Q, MAX_NEG},
		// top of the degree range, saturating arguments
		'{6'd63, ONE_Q,         1'b1, ONE_Q, ONE_Q},
		'{6'd63, NEG_ONE,       1'b1, ONE_Q, NEG_ONE},
		'{6'd63, HALF_Q,        1'b0, 32'sh0, 32'sh0},
		'{6'd63, MAX_POS,       1'b0, 32'sh0, 32'sh0},
		'{6'd63, MAX_NEG,       1'b0, 32'sh0, 32'sh0},
		// small degree, small and signed arguments
		'{6'd2,  32'sh0,        1'b0, 32'sh0, 32'sh0},
		'{6'd2,  HALF_Q,        1'b0, 32'sh0, 32'sh0},
		'{6'd2,  NEG_HALF,      1'b0, 32'sh0, 32'sh0},
		'{6'd2,  32'sh1,        1'b0, 32'sh0, 32'sh0},
		'{6'd2,  32'shFFFF_FFFF, 1'b0, 32'sh0, 32'sh0},
		// rounding-heavy values and just past the endpoints
		'{6'd5,  32'sh2D41_3CCD, 1'b0, 32'sh0, 32'sh0},
		'{6'd5,  32'shECCC_CCCD, 1'b0, 32'sh0, 32'sh0},
		'{6'd5,  32'sh4000_0001, 1'b0, 32'sh0, 32'sh0},
		'{6'd5,  32'shBFFF_FFFF, 1'b0, 32'sh0, 32'sh0}
	};

	// random phases: degree setting and argument count; mostly small degrees
	localparam int N_PHASES    = 10;
	localparam int HOLD_PHASE  = 6;
	localparam int PAUSE_PHASE = 2;
	localparam logic [DEG_W-1:0] PHASE_DEG [N_PHASES] =
		'{6'd1, 6'd2, 6'd3, 6'd5, 6'd8, 6'd0, 6'd13, 6'd20, 6'd63, 6'd50};
	localparam int PHASE_ITEMS [N_PHASES] = '{40, 40, 30, 30, 25, 20, 15, 8, 4, 4};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [DEG_W-1:0] cfg_wr_data;

	lfr_arg_if arg_ch ();
	lfr_res_if res_ch ();

	legendre_forward_recurrence_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.arg         (arg_ch),
		.poly        (res_ch)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [DEG_W-1:0]         top_degree;
	logic signed [DATA_W-1:0] arg_copy;
	logic signed [DATA_W-1:0] p_prev;
	logic signed [DATA_W-1:0] p_curr;
	logic [DEG_W-1:0]         deg_count;
	poly_res_t                poly_expected [$];

	int fail_count   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int sat_seen     = 0;
	int deg_writes   = 0;
	int burst_left   = 0;
	int hold_asked   = 0;
	int hold_taken   = 0;

	// P_{l+1} from P_l and P_{l-1}: exact numerator, one rounded division
	function automatic logic signed [DATA_W-1:0] bonnet_next(input int l,
		input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] pl,
		input logic signed [DATA_W-1:0] pm);
		logic signed [127:0] num;
		logic signed [127:0] sub;
		logic [127:0]        mag;
		logic [127:0]        dvs;
		logic [127:0]        quo;
		logic [127:0]        lim;
		bit                  neg;
		num = 128'(x);
		num = num * pl;
		num = num * (2 * l + 1);
		sub = 128'(pm);
		sub = sub * l;
		sub = sub <<< FRAC_BITS;
		num = num - sub;
		neg = num < 0;
		mag = neg ? -num : num;
		dvs = 128'(l + 1);
		dvs = dvs << FRAC_BITS;
		// ties away from zero: round the magnitude
		quo = (mag + (dvs >> 1)) / dvs;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (quo > lim)
			quo = lim;
		return neg ? -quo[DATA_W-1:0] : quo[DATA_W-1:0];
	endfunction

	// expand one argument into its expected run of results
	function automatic void predict_run(input logic signed [DATA_W-1:0] x, input bit typed,
		input logic signed [DATA_W-1:0] p_even, input logic signed [DATA_W-1:0] p_odd);
		poly_res_t                r;
		logic signed [DATA_W-1:0] nxt;
		arg_copy  = x;
		p_prev    = '0;
		p_curr    = ONE_Q;
		deg_count = '0;
		for (int l = 0; l <= top_degree; l++) begin
			if (l == 1) begin
				p_prev = p_curr;
				p_curr = arg_copy;
			end else if (l > 1) begin
				nxt    = bonnet_next(l - 1, arg_copy, p_curr, p_prev);
				p_prev = p_curr;
				p_curr = nxt;
			end
			if (p_curr == MAX_POS || p_curr == MAX_NEG)
				sat_seen++;
			deg_count = l[DEG_W-1:0];
			r.degree  = deg_count;
			r.p_value = !typed ? p_curr : (l == 0) ? ONE_Q : (l[0] ? p_odd : p_even);
			r.last    = (l == top_degree);
			poly_expected.push_back(r);
		end
	endfunction

	// random argument: mostly in [-1,1], some endpoints, some full 32-bit
	function automatic logic signed [DATA_W-1:0] pick_arg();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
		if (sel < 70) begin
			case ($urandom_range(0, 4))
				0: return ONE_Q;
				1: return NEG_ONE;
				2: return 32'sh0;
				3: return 32'sh1;
				default: return 32'shFFFF_FFFF;
			endcase
		end
		if (sel < 85) begin
			case ($urandom_range(0, 2))
				0: return ONE_Q - $urandom_range(0, 1023);
				1: return NEG_ONE + $urandom_range(0, 1023);
				default: return $urandom_range(0, 2047) - 1024;
			endcase
		end
		return $urandom;
	endfunction

	function automatic void report(input string field, input logic signed [63:0] exp_v,
		input logic signed [63:0] act_v);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
	endfunction

	// one argument request; valid stays up for a following request
	task automatic send_arg(input logic signed [DATA_W-1:0] x, input bit typed,
		input logic signed [DATA_W-1:0] p_even, input logic signed [DATA_W-1:0] p_odd);
		arg_ch.valid   <= 1'b1;
		arg_ch.x_value <= x;
		do
			@(posedge clk);
		while (!(arg_ch.valid && arg_ch.ready));
		predict_run(x, typed, p_even, p_odd);
		items_sent++;
	endtask

	task automatic idle(input int n);
		if (n > 0) begin
			arg_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// bursts of requests with random gaps; steady phases have no gaps
	task automatic pace_sender(input bit steady);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 8);
			if (!steady)
				idle(($urandom_range(0, 4) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 3));
		end
	endtask

	task automatic drain_results();
		arg_ch.valid <= 1'b0;
		while (poly_expected.size() != 0)
			@(posedge clk);
	endtask

	// register write only once the block has emptied
	task automatic set_degree(input logic [DEG_W-1:0] d);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= d;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		top_degree = d;
		deg_writes++;
	endtask

	// stimulus
	initial begin
		bit steady;
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_wr_data    <= '0;
		arg_ch.valid   <= 1'b0;
		arg_ch.x_value <= '0;
		top_degree = MAX_DEGREE_RST;
		arg_copy   = '0;
		p_prev     = '0;
		p_curr     = '0;
		deg_count  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].deg != top_degree)
				set_degree(DIR_ROWS[i].deg);
			send_arg(DIR_ROWS[i].x, DIR_ROWS[i].typed, DIR_ROWS[i].p_even, DIR_ROWS[i].p_odd);
			pace_sender(1'b0);
		end

		// random phases
		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_degree(PHASE_DEG[ph]);
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS[ph]; k++) begin
				// receiver holds off while requests keep coming
				if (ph == HOLD_PHASE && k == 2)
					hold_asked++;
				// sender waits for every pending result
				if (ph == PAUSE_PHASE && k == 15)
					drain_results();
				send_arg(pick_arg(), 1'b0, '0, '0);
				if (hold_asked == hold_taken)
					pace_sender(steady);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d arguments over %0d max_degree writes (0, 1, 50 and 63 included).",
			items_sent, deg_writes);
		$display("%0d results checked, %0d expected at saturation, %0d errors.",
			results_seen, sat_seen, fail_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// receiver: rotating stall patterns plus one long hold-off on request
	initial begin
		stall_mode_t mode;
		int          cyc;
		mode = RDY_ALWAYS;
		cyc  = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_asked != hold_taken) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_taken++;
			end else begin
				if (cyc % 64 == 0)
					mode = stall_mode_t'($urandom_range(0, 3));
				case (mode)
					RDY_ALWAYS: res_ch.ready <= 1'b1;
					RDY_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
					RDY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
					default:    res_ch.ready <= ((cyc % 8) < 5);
				endcase
				cyc++;
				@(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		poly_res_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (poly_expected.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none, actual degree %0d value %0d",
					$time, res_ch.degree, res_ch.p_value);
			end else begin
				exp_r = poly_expected.pop_front();
				results_seen++;
				if (res_ch.degree !== exp_r.degree)
					report("degree", exp_r.degree, res_ch.degree);
				if (res_ch.p_value !== exp_r.p_value)
					report("p_value", exp_r.p_value, res_ch.p_value);
				if (res_ch.last !== exp_r.last)
					report("last", exp_r.last, res_ch.last);
			end
		end
	end

	// watchdog: cycles with no request, result or register write
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((arg_ch.valid && arg_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: nothing moved for %0d cycles, %0d results pending",
			$time, STALL_LIMIT, poly_expected.size());
		$display("Verification failed");
		$finish;
	end

endmodule
